// ===== src/assert_macros.svh =====
// Assertion helper macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== src/lsfs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip frame sequencer package
// Shared constants, codes and types.
// ----------------------------------------------------------------------------
package lsfs_pkg;
   localparam int unsigned PATTERN_DEPTH = 512;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   typedef enum logic [2:0] {
      KIND_WRITE = 3'd0,
      KIND_START = 3'd1,
      KIND_SLOT = 3'd2,
      KIND_PERIOD = 3'd3,
      KIND_TRIG = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      REG_LED_COUNT = 3'd0,
      REG_GROUP_COUNT = 3'd1,
      REG_SEQ_COUNT = 3'd2,
      REG_PERIOD = 3'd3,
      REG_REPS = 3'd4,
      REG_TRIG_EN = 3'd5,
      REG_TRIG_DELAY = 3'd6,
      REG_TRIG_WIDTH = 3'd7
   } reg_type;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONES = 8'hFF;
endpackage

// ===== src/led_strip_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED strip frame sequencer
// Builds APA102-style strip frames from a pattern memory, at most one byte per slot.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one event word per handshake. req_tuser = kind (write,
//   start, byte slot, period tick, trigger tick). req_tdata carries the
//   pattern address and byte for writes.
//   rsp_ channel: exactly one word per event: byte_valid/spi_byte plus
//   strip_enable, trigger_level and running flags.
//   csr_ port: write-only registers, taken at once, no read-back.
// Timing: an accepted word passes the pattern read (ST_READ), then the
//   update (ST_EXEC); the response is then held in an output register
//   (ST_OUT). No new word is accepted until the response has been taken.
//   Any config write to led_count or group_count starts a serial division
//   of LEDs per group; req_tready stays low until it is done.
// Reset: all sequencing state clears, trigger pin idles high, registers
//   take their default values; pattern memory is not cleared.
// Stall: if the receiver holds rsp_tready low, the response waits and no
//   further word is accepted.
// ----------------------------------------------------------------------------
module led_strip_frame_sequencer #(
   parameter int unsigned PATTERN_DEPTH = lsfs_pkg::PATTERN_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pattern_addr[8:0], pattern_data[16:9]
   input  logic [2:0]  req_tuser,  // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // byte_valid[0], spi_byte[8:1], strip_enable[9],
                                   // trigger_level[10], running[11]
   input  logic        csr_wen,
   input  logic [lsfs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lsfs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int unsigned AW = $clog2(PATTERN_DEPTH);

   typedef enum logic [2:0] {
      PH_IDLE, PH_START, PH_LEDS, PH_END, PH_CLOSE, PH_WAIT
   } phase_type;
   typedef enum logic [1:0] {TR_OFF, TR_DELAY, TR_WIDTH} trig_type;
   typedef enum logic [1:0] {ST_READY, ST_READ, ST_EXEC, ST_OUT} state_type;

   // configuration
   logic [15:0] led_count_ff;
   logic [9:0]  group_count_ff, seq_count_ff;
   logic [31:0] period_ff, reps_ff, tdelay_ff, twidth_ff;
   logic        trig_en_ff;

   state_type   state_ff;
   phase_type   phase_ff;
   trig_type    tphase_ff;
   logic [12:0] bcnt_ff;
   logic [15:0] lig_ff;
   logic [9:0]  gidx_ff, seqd_ff;
   logic [31:0] repd_ff, pcnt_ff, tcnt_ff;
   logic        tpin_ff;
   logic [2:0]  kind_ff;
   logic [AW-1:0] waddr_ff, raddr_ff;
   logic [7:0]  wdata_ff;
   logic        obv_ff;
   logic [7:0]  obyte_ff;
   logic [19:0] seq_base; // seqd * group_count, live register value
   logic [7:0]  rd_data;
   logic        div_busy, div_start;
   logic [15:0] per_group;

   // pattern read address: seqd * group_count + group index, mod depth
   logic [AW-1:0] rd_addr;
   assign seq_base = 20'(seqd_ff) * 20'(group_count_ff);
   assign rd_addr = AW'(seq_base + 20'(gidx_ff));

   lsfs_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (state_ff == ST_EXEC && kind_ff == lsfs_pkg::KIND_WRITE),
      .wr_addr(waddr_ff),
      .wr_data(wdata_ff),
      .rd_addr(raddr_ff),
      .rd_data(rd_data)
   );

   assign div_start = csr_wen && (csr_addr == lsfs_pkg::REG_LED_COUNT ||
                                  csr_addr == lsfs_pkg::REG_GROUP_COUNT);

   lsfs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(csr_addr == lsfs_pkg::REG_LED_COUNT ? csr_wdata[15:0] : led_count_ff),
      .divisor (csr_addr == lsfs_pkg::REG_GROUP_COUNT ?
                ((csr_wdata[9:0] == 10'd0) ? 10'd1 : csr_wdata[9:0]) :
                ((group_count_ff == 10'd0) ? 10'd1 : group_count_ff)),
      .busy    (div_busy),
      .quotient(per_group)
   );

   assign req_tready = (state_ff == ST_READY) && !div_busy && !div_start;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {4'd0, (phase_ff != PH_IDLE), tpin_ff,
                       (phase_ff != PH_IDLE && phase_ff != PH_WAIT), obyte_ff, obv_ff};

   logic [9:0]  groups;
   logic [12:0] end_len;
   assign groups = (group_count_ff == 10'd0) ? 10'd1 : group_count_ff;
   assign end_len = 13'((17'(led_count_ff) + 17'd15) >> 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= 16'd1;
         group_count_ff <= 10'd1;
         seq_count_ff <= '0;
         period_ff <= '0;
         reps_ff <= '0;
         trig_en_ff <= 1'b0;
         tdelay_ff <= '0;
         twidth_ff <= '0;
         state_ff <= ST_READY;
         phase_ff <= PH_IDLE;
         tphase_ff <= TR_OFF;
         bcnt_ff <= '0;
         lig_ff <= '0;
         gidx_ff <= '0;
         seqd_ff <= '0;
         repd_ff <= '0;
         pcnt_ff <= '0;
         tcnt_ff <= '0;
         tpin_ff <= 1'b1;
         obv_ff <= 1'b0;
         obyte_ff <= '0;
      end else begin
         if (csr_wen) begin
            unique case (lsfs_pkg::reg_type'(csr_addr))
               lsfs_pkg::REG_LED_COUNT:   led_count_ff <= csr_wdata[15:0];
               lsfs_pkg::REG_GROUP_COUNT: group_count_ff <= csr_wdata[9:0];
               lsfs_pkg::REG_SEQ_COUNT:   seq_count_ff <= csr_wdata[9:0];
               lsfs_pkg::REG_PERIOD:      period_ff <= csr_wdata;
               lsfs_pkg::REG_REPS:        reps_ff <= csr_wdata;
               lsfs_pkg::REG_TRIG_EN:     trig_en_ff <= csr_wdata[0];
               lsfs_pkg::REG_TRIG_DELAY:  tdelay_ff <= csr_wdata;
               lsfs_pkg::REG_TRIG_WIDTH:  twidth_ff <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_READY: begin
               if (req_tvalid && req_tready) begin
                  kind_ff <= req_tuser;
                  waddr_ff <= AW'(req_tdata[8:0]);
                  wdata_ff <= req_tdata[16:9];
                  raddr_ff <= rd_addr;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_EXEC;
            ST_EXEC: begin
               obv_ff <= 1'b0;
               obyte_ff <= lsfs_pkg::BYTE_ZERO;
               state_ff <= ST_OUT;
               priority case (kind_ff)
                  lsfs_pkg::KIND_START: begin
                     if (phase_ff == PH_IDLE) begin
                        seqd_ff <= '0;
                        repd_ff <= '0;
                        phase_ff <= PH_START;
                        bcnt_ff <= 13'd1;
                        lig_ff <= '0;
                        gidx_ff <= '0;
                        obv_ff <= 1'b1;
                     end
                  end
                  lsfs_pkg::KIND_SLOT: begin
                     priority case (phase_ff)
                        PH_START: begin
                           obv_ff <= 1'b1;
                           if (bcnt_ff + 13'd1 >= 13'd4) begin
                              bcnt_ff <= '0;
                              phase_ff <= PH_LEDS;
                           end else begin
                              bcnt_ff <= bcnt_ff + 13'd1;
                           end
                        end
                        PH_LEDS: begin
                           obv_ff <= 1'b1;
                           if (bcnt_ff == 13'd0) begin
                              obyte_ff <= lsfs_pkg::BYTE_ONES;
                              bcnt_ff <= 13'd1;
                           end else begin
                              obyte_ff <= rd_data;
                              if (bcnt_ff < 13'd3) begin
                                 bcnt_ff <= bcnt_ff + 13'd1;
                              end else begin
                                 bcnt_ff <= '0;
                                 if (17'(lig_ff) + 17'd1 >= 17'(per_group)) begin
                                    lig_ff <= '0;
                                    if (gidx_ff + 10'd1 >= groups) begin
                                       gidx_ff <= '0;
                                       phase_ff <= PH_END;
                                    end else begin
                                       gidx_ff <= gidx_ff + 10'd1;
                                    end
                                 end else begin
                                    lig_ff <= lig_ff + 16'd1;
                                 end
                              end
                           end
                        end
                        PH_END: begin
                           obv_ff <= 1'b1;
                           obyte_ff <= lsfs_pkg::BYTE_ONES;
                           if (bcnt_ff + 13'd1 >= end_len) begin
                              bcnt_ff <= '0;
                              phase_ff <= PH_CLOSE;
                           end else begin
                              bcnt_ff <= bcnt_ff + 13'd1;
                           end
                        end
                        PH_CLOSE: begin
                           seqd_ff <= seqd_ff + 10'd1;
                           phase_ff <= PH_WAIT;
                           pcnt_ff <= '0;
                           if (trig_en_ff) begin
                              tphase_ff <= TR_DELAY;
                              tcnt_ff <= '0;
                           end
                        end
                        default: ;
                     endcase
                  end
                  lsfs_pkg::KIND_PERIOD: begin
                     if (phase_ff == PH_WAIT) begin
                        if (pcnt_ff + 32'd1 >= period_ff) begin
                           pcnt_ff <= '0;
                           if (seqd_ff < seq_count_ff || reps_ff == 32'd0 ||
                               repd_ff != reps_ff - 32'd1) begin
                              if (!(seqd_ff < seq_count_ff)) begin
                                 seqd_ff <= '0;
                                 if (reps_ff != 32'd0) repd_ff <= repd_ff + 32'd1;
                              end
                              phase_ff <= PH_START;
                              bcnt_ff <= 13'd1;
                              lig_ff <= '0;
                              gidx_ff <= '0;
                              obv_ff <= 1'b1;
                           end else begin
                              seqd_ff <= '0;
                              repd_ff <= '0;
                              phase_ff <= PH_IDLE;
                           end
                        end else begin
                           pcnt_ff <= pcnt_ff + 32'd1;
                        end
                     end
                  end
                  lsfs_pkg::KIND_TRIG: begin
                     if (tphase_ff == TR_DELAY) begin
                        if (tcnt_ff + 32'd1 >= tdelay_ff) begin
                           tcnt_ff <= '0;
                           tpin_ff <= 1'b0;
                           tphase_ff <= TR_WIDTH;
                        end else begin
                           tcnt_ff <= tcnt_ff + 32'd1;
                        end
                     end else if (tphase_ff == TR_WIDTH) begin
                        if (tcnt_ff + 32'd1 >= twidth_ff) begin
                           tcnt_ff <= '0;
                           tpin_ff <= 1'b1;
                           tphase_ff <= TR_OFF;
                        end else begin
                           tcnt_ff <= tcnt_ff + 32'd1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            ST_OUT: if (rsp_tready) state_ff <= ST_READY;
            default: state_ff <= ST_READY;
         endcase
      end
   end
endmodule

// ===== src/lsfs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/lsfs_divider.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 16 / 10 bit unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsfs_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [9:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [15:0] quot_ff, quot_in;
   logic [10:0] rem_ff, rem_in;
   logic [9:0]  dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [11:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quot_ff[15]} - {2'b00, dsr_ff};
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         if (!trial[11]) begin
            rem_in = trial[10:0];
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[9:0], quot_ff[15]};
            quot_in = {quot_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         quot_ff <= 16'd1; // 1 LED over 1 group, the register defaults
      end else begin
         cnt_ff <= cnt_in;
         quot_ff <= quot_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy = (cnt_ff != 5'd0);
   assign quotient = quot_ff;
endmodule

// ===== src/lsfs_checker.sv =====
// ----------------------------------------------------------------------------
// LED strip frame sequencer checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lsfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   `CHK_IMPL(a_no_overlap, clock, reset, req_tready, !rsp_tvalid, "ready while response pending")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `CHK_IMPL(a_zero_byte, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[8:1] == 8'd0, "byte without valid")
   `CHK_IMPL(a_strip_run, clock, reset, rsp_tvalid && rsp_tdata[9], rsp_tdata[11], "strip on while idle")
   `CHK_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready, "accepted twice in a row")
endmodule

bind led_strip_frame_sequencer lsfs_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
